[hdl/pbd_pkg.sv]
// ---------------------------------------------------------------------------
// pbd_pkg - shared types and constants of the pulse beat detector
// Field widths, register indexes, reset values and fixed arithmetic constants.
// ---------------------------------------------------------------------------
package pbd_pkg;

  // Field and state widths
  localparam int ELAPSED_W = 32;
  localparam int IBI_W     = 16;
  localparam int LEVEL_W   = 10;
  localparam int PERIOD_W  = 8;
  localparam int REFR_W    = 12;
  localparam int TMO_W     = 16;
  localparam int BPM_W     = 8;
  localparam int DIVISOR_W = 16;
  localparam int CFG_IDX_W = 4;
  localparam int CFG_DATA_W = 16;

  typedef logic [LEVEL_W-1:0]   level_t;
  typedef logic [IBI_W-1:0]     ibi_t;
  typedef logic [ELAPSED_W-1:0] msec_t;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_PERIOD = 4'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_REFR   = 4'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_TMO    = 4'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_LEVEL  = 4'd3;

  // Reset values
  localparam logic [PERIOD_W-1:0] PERIOD_RST = 8'd2;
  localparam logic [REFR_W-1:0]   REFR_RST   = 12'd250;
  localparam logic [TMO_W-1:0]    TMO_RST    = 16'd2500;
  localparam level_t              LEVEL_RST  = 10'd512;
  localparam ibi_t                IBI_RST    = 16'd600;

  // Settling interval is three fifths of the last interval: the fifth is
  // stored, the tripling is done serially during the timing pass.
  localparam int   SETTLE_DIV  = 5;
  localparam ibi_t SETTLE_Q_RST = IBI_W'(600 / SETTLE_DIV);

  // Beats per minute from an interval in ms
  localparam int                 BPM_NUM = 60000;
  localparam logic [BPM_W-1:0]   BPM_MAX = 8'd255;

endpackage

[hdl/pulse_beat_detector.sv]
// ---------------------------------------------------------------------------
// pulse_beat_detector - heartbeat detection on pulse sensor samples
// Each accepted sample goes through a bit-serial timing pass (ST_ACC), a
//   decision state (ST_DECIDE) and the output state (ST_OUT).
// A beat adds serial divisions before the output state: one on the first beat,
//   two or three on later beats.
// A new sample is taken only after the previous result is loaded into the output register.
// Reset (synchronous) restores the defaults; the window is seeded by the second beat.
// ---------------------------------------------------------------------------
module pulse_beat_detector #(
  parameter int WINDOW_BEATS = 10
) (
  input  logic                            clk,
  input  logic                            rst_n,
  // sample channel
  input  logic                            in_valid,
  output logic                            in_stall,
  input  logic [pbd_pkg::LEVEL_W-1:0]     in_sample,
  // result channel
  output logic                            out_valid,
  input  logic                            out_stall,
  output logic                            out_beat_found,
  output logic                            out_pulse_active,
  output logic [pbd_pkg::BPM_W-1:0]       out_bpm,
  output logic [pbd_pkg::IBI_W-1:0]       out_ibi_ms,
  // configuration write channel
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [pbd_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [pbd_pkg::CFG_DATA_W-1:0]  cfg_data
);

  localparam int TOTAL_W = pbd_pkg::IBI_W + $clog2(WINDOW_BEATS);
  localparam int CNT_W   = $clog2(pbd_pkg::ELAPSED_W);
  localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(pbd_pkg::ELAPSED_W - 1);
  localparam logic [CNT_W-1:0] CNT_HI   = CNT_W'(pbd_pkg::IBI_W);

  localparam logic [2:0] ST_IDLE   = 3'd0;
  localparam logic [2:0] ST_ACC    = 3'd1;
  localparam logic [2:0] ST_DECIDE = 3'd2;
  localparam logic [2:0] ST_AVG    = 3'd3;
  localparam logic [2:0] ST_RATE   = 3'd4;
  localparam logic [2:0] ST_SETQ   = 3'd5;
  localparam logic [2:0] ST_OUT    = 3'd6;

  // configuration
  logic [pbd_pkg::PERIOD_W-1:0] period_r;
  logic [pbd_pkg::REFR_W-1:0]   refr_r;
  logic [pbd_pkg::TMO_W-1:0]    tmo_r;
  pbd_pkg::level_t              level_r;

  // detector state
  logic [2:0]           state_r, state_nxt;
  pbd_pkg::msec_t       elapsed_r, elapsed_nxt;
  pbd_pkg::msec_t       last_beat_r;
  pbd_pkg::ibi_t        bi_r;
  pbd_pkg::ibi_t        settle_q_r;
  pbd_pkg::level_t      thr_r, peak_r, trough_r;
  logic                 in_pulse_r, first_r, second_r, found_r;
  logic [pbd_pkg::BPM_W-1:0] bpm_r;
  pbd_pkg::level_t      sample_r;
  pbd_pkg::ibi_t        win_r [WINDOW_BEATS];
  logic [TOTAL_W-1:0]   total_r, total_nxt;

  // serial timing pass
  logic [CNT_W-1:0]             acc_cnt_r;
  logic [pbd_pkg::PERIOD_W-1:0] period_sh_r;
  logic [pbd_pkg::REFR_W-1:0]   refr_sh_r;
  logic [pbd_pkg::TMO_W-1:0]    tmo_sh_r;
  pbd_pkg::ibi_t                q_sh_r;
  pbd_pkg::ibi_t                gap_lo_r;
  logic qprev_r, c3_r, carry_r, borrow_r;
  logic c3_nxt, carry_nxt, borrow_nxt;
  logic gt_refr_r, gt_settle_r, gt_tmo_r, hi_nz_r;
  logic sum_bit, gap_bit, settle_bit, lb_bit, q_bit;

  // decision
  logic            beat, end_pulse;
  pbd_pkg::ibi_t   bi_new;
  pbd_pkg::level_t peak_upd, trough_upd, mid;

  // divider
  logic                          div_start, div_done;
  logic [TOTAL_W-1:0]            div_dividend, div_quotient;
  logic [pbd_pkg::DIVISOR_W-1:0] div_divisor;
  logic                          avg_zero;

  // output register
  logic                      out_valid_r, out_found_r, out_pulse_r;
  logic [pbd_pkg::BPM_W-1:0] out_bpm_r;
  pbd_pkg::ibi_t             out_ibi_r;

  logic in_take, out_take, out_load;

  assign in_take   = in_valid && !in_stall;
  assign out_take  = out_valid_r && !out_stall;
  assign out_load  = (state_r == ST_OUT) && (!out_valid_r || !out_stall);
  assign in_stall  = (state_r != ST_IDLE);
  assign cfg_ready = 1'b1;

  // Write configuration registers; unknown indexes are dropped
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      period_r <= pbd_pkg::PERIOD_RST;
      refr_r   <= pbd_pkg::REFR_RST;
      tmo_r    <= pbd_pkg::TMO_RST;
      level_r  <= pbd_pkg::LEVEL_RST;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        pbd_pkg::CFG_PERIOD: period_r <= cfg_data[pbd_pkg::PERIOD_W-1:0];
        pbd_pkg::CFG_REFR:   refr_r   <= cfg_data[pbd_pkg::REFR_W-1:0];
        pbd_pkg::CFG_TMO:    tmo_r    <= cfg_data[pbd_pkg::TMO_W-1:0];
        pbd_pkg::CFG_LEVEL:  level_r  <= cfg_data[pbd_pkg::LEVEL_W-1:0];
        default: ;
      endcase
    end
  end

  // Bit-serial timing: new elapsed = elapsed + period, gap = new - last beat,
  // settle = 3 * (interval / 5); compare gap against each limit LSB first
  always_comb begin
    lb_bit     = last_beat_r[0];
    q_bit      = q_sh_r[0];
    sum_bit    = elapsed_r[0] ^ period_sh_r[0] ^ carry_r;
    carry_nxt  = (elapsed_r[0] & period_sh_r[0]) | (carry_r & (elapsed_r[0] ^ period_sh_r[0]));
    gap_bit    = sum_bit ^ lb_bit ^ borrow_r;
    borrow_nxt = (~sum_bit & lb_bit) | (~(sum_bit ^ lb_bit) & borrow_r);
    settle_bit = q_bit ^ qprev_r ^ c3_r;
    c3_nxt     = (q_bit & qprev_r) | (c3_r & (q_bit ^ qprev_r));
    elapsed_nxt = {sum_bit, elapsed_r[pbd_pkg::ELAPSED_W-1:1]};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      acc_cnt_r <= '0;
    end else if (in_take) begin
      acc_cnt_r <= '0;
    end else if (state_r == ST_ACC) begin
      acc_cnt_r <= acc_cnt_r + 1'b1;
    end
  end

  // Load the shift registers on a new transaction, then shift
  always_ff @(posedge clk) begin
    if (in_take) begin
      sample_r    <= in_sample;
      period_sh_r <= period_r;
      refr_sh_r   <= refr_r;
      tmo_sh_r    <= tmo_r;
      q_sh_r      <= settle_q_r;
      qprev_r     <= 1'b0;
      c3_r        <= 1'b0;
      carry_r     <= 1'b0;
      borrow_r    <= 1'b0;
      gt_refr_r   <= 1'b0;
      gt_settle_r <= 1'b0;
      gt_tmo_r    <= 1'b0;
      hi_nz_r     <= 1'b0;
    end else if (state_r == ST_ACC) begin
      period_sh_r <= {1'b0, period_sh_r[pbd_pkg::PERIOD_W-1:1]};
      refr_sh_r   <= {1'b0, refr_sh_r[pbd_pkg::REFR_W-1:1]};
      tmo_sh_r    <= {1'b0, tmo_sh_r[pbd_pkg::TMO_W-1:1]};
      q_sh_r      <= {1'b0, q_sh_r[pbd_pkg::IBI_W-1:1]};
      qprev_r     <= q_bit;
      c3_r        <= c3_nxt;
      carry_r     <= carry_nxt;
      borrow_r    <= borrow_nxt;
      if (gap_bit != refr_sh_r[0]) gt_refr_r   <= gap_bit;
      if (gap_bit != settle_bit)   gt_settle_r <= gap_bit;
      if (gap_bit != tmo_sh_r[0])  gt_tmo_r    <= gap_bit;
      if (acc_cnt_r >= CNT_HI) begin
        hi_nz_r <= hi_nz_r | gap_bit;
      end else begin
        gap_lo_r <= {gap_bit, gap_lo_r[pbd_pkg::IBI_W-1:1]};
      end
    end
  end

  // Beat decision and threshold tracking
  always_comb begin
    beat = gt_refr_r && (sample_r > thr_r) && !in_pulse_r && gt_settle_r;
    bi_new = hi_nz_r ? '1 : gap_lo_r;
    trough_upd = (sample_r < thr_r && gt_settle_r && sample_r < trough_r) ? sample_r : trough_r;
    peak_upd   = (sample_r > thr_r && sample_r > peak_r) ? sample_r : peak_r;
    end_pulse  = (sample_r < thr_r) && (in_pulse_r || beat);
    if (peak_upd >= trough_upd) begin
      mid = ((peak_upd - trough_upd) >> 1) + trough_upd;
    end else begin
      mid = trough_upd - ((trough_upd - peak_upd) >> 1);
    end
    if (second_r) begin
      total_nxt = TOTAL_W'(bi_new) * TOTAL_W'(WINDOW_BEATS);
    end else begin
      total_nxt = total_r - TOTAL_W'(win_r[0]) + TOTAL_W'(bi_new);
    end
  end

  // Divider operand selection
  assign avg_zero = (div_quotient == '0);

  always_comb begin
    div_start    = 1'b0;
    div_dividend = TOTAL_W'(bi_r);
    div_divisor  = pbd_pkg::DIVISOR_W'(pbd_pkg::SETTLE_DIV);
    case (state_r)
      ST_DECIDE: begin
        if (beat) begin
          div_start = 1'b1;
          if (first_r) begin
            div_dividend = TOTAL_W'(bi_new);
          end else begin
            div_dividend = total_nxt;
            div_divisor  = pbd_pkg::DIVISOR_W'(WINDOW_BEATS);
          end
        end
      end
      ST_AVG: begin
        if (div_done) begin
          div_start = 1'b1;
          if (!avg_zero) begin
            div_dividend = TOTAL_W'(pbd_pkg::BPM_NUM);
            div_divisor  = div_quotient[pbd_pkg::DIVISOR_W-1:0];
          end
        end
      end
      ST_RATE: begin
        div_start = div_done;
      end
      default: ;
    endcase
  end

  pbd_div #(
    .DW(TOTAL_W)
  ) u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (div_dividend),
    .divisor  (div_divisor),
    .quotient (div_quotient),
    .done     (div_done)
  );

  // Sequencer
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE:   if (in_take) state_nxt = ST_ACC;
      ST_ACC:    if (acc_cnt_r == CNT_LAST) state_nxt = ST_DECIDE;
      ST_DECIDE: begin
        if (!beat) state_nxt = ST_OUT;
        else if (first_r) state_nxt = ST_SETQ;
        else state_nxt = ST_AVG;
      end
      ST_AVG:    if (div_done) state_nxt = avg_zero ? ST_SETQ : ST_RATE;
      ST_RATE:   if (div_done) state_nxt = ST_SETQ;
      ST_SETQ:   if (div_done) state_nxt = ST_OUT;
      ST_OUT:    if (out_load) state_nxt = ST_IDLE;
      default:   state_nxt = ST_IDLE;
    endcase
  end

  // Detector state updates
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      elapsed_r   <= '0;
      last_beat_r <= '0;
      bi_r        <= pbd_pkg::IBI_RST;
      settle_q_r  <= pbd_pkg::SETTLE_Q_RST;
      thr_r       <= pbd_pkg::LEVEL_RST;
      peak_r      <= pbd_pkg::LEVEL_RST;
      trough_r    <= pbd_pkg::LEVEL_RST;
      in_pulse_r  <= 1'b0;
      first_r     <= 1'b1;
      second_r    <= 1'b0;
      found_r     <= 1'b0;
      bpm_r       <= '0;
    end else begin
      state_r <= state_nxt;
      case (state_r)
        ST_ACC: begin
          elapsed_r   <= elapsed_nxt;
          last_beat_r <= {lb_bit, last_beat_r[pbd_pkg::ELAPSED_W-1:1]};
        end
        ST_DECIDE: begin
          found_r  <= beat && !first_r;
          peak_r   <= peak_upd;
          trough_r <= trough_upd;
          if (beat) begin
            in_pulse_r  <= 1'b1;
            bi_r        <= bi_new;
            last_beat_r <= elapsed_r;
            if (first_r) begin
              first_r  <= 1'b0;
              second_r <= 1'b1;
            end else begin
              second_r <= 1'b0;
            end
          end
          // the first beat only starts timing: skip pulse end and timeout
          if (!(beat && first_r)) begin
            if (end_pulse) begin
              in_pulse_r <= 1'b0;
              thr_r      <= mid;
              peak_r     <= mid;
              trough_r   <= mid;
            end
            if (gt_tmo_r) begin
              thr_r       <= level_r;
              peak_r      <= level_r;
              trough_r    <= level_r;
              last_beat_r <= elapsed_r;
              first_r     <= 1'b1;
              second_r    <= 1'b0;
            end
          end
        end
        ST_AVG: begin
          if (div_done && avg_zero) bpm_r <= pbd_pkg::BPM_MAX;
        end
        ST_RATE: begin
          if (div_done) begin
            if (|div_quotient[TOTAL_W-1:pbd_pkg::BPM_W]) begin
              bpm_r <= pbd_pkg::BPM_MAX;
            end else begin
              bpm_r <= div_quotient[pbd_pkg::BPM_W-1:0];
            end
          end
        end
        ST_SETQ: begin
          if (div_done) settle_q_r <= div_quotient[pbd_pkg::IBI_W-1:0];
        end
        default: ;
      endcase
    end
  end

  // Interval window and its running sum; seeded on the second beat
  always_ff @(posedge clk) begin
    if (state_r == ST_DECIDE && beat && !first_r) begin
      total_r <= total_nxt;
      for (int k = 0; k < WINDOW_BEATS; k++) begin
        if (second_r || k == WINDOW_BEATS - 1) begin
          win_r[k] <= bi_new;
        end else begin
          win_r[k] <= win_r[k+1];
        end
      end
    end
  end

  // Output register: hold the result until the transaction is taken
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_take) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_found_r <= found_r;
      out_pulse_r <= in_pulse_r;
      out_bpm_r   <= bpm_r;
      out_ibi_r   <= bi_r;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_beat_found   = out_found_r;
  assign out_pulse_active = out_pulse_r;
  assign out_bpm          = out_bpm_r;
  assign out_ibi_ms       = out_ibi_r;

  // Checks
  a_take_starts_pass: assert property (@(posedge clk) disable iff (!rst_n)
    in_take |=> state_r == ST_ACC)
    else $error("accepted sample did not start the timing pass");

  a_pass_length: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_ACC && acc_cnt_r == CNT_LAST) |=> state_r == ST_DECIDE)
    else $error("timing pass did not end after its last bit");

  a_beat_flags: assert property (@(posedge clk) disable iff (!rst_n)
    !(first_r && second_r))
    else $error("first and second beat flags both set");

  a_beat_in_pulse: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (!out_found_r || out_pulse_r))
    else $error("beat reported outside a pulse");

endmodule

[hdl/pbd_div.sv]
// ---------------------------------------------------------------------------
// pbd_div - bit-serial restoring divider
// Produces one quotient bit per cycle, most significant first; the quotient
// builds up in the dividend shift register. Raises done for one cycle.
// ---------------------------------------------------------------------------
module pbd_div #(
  parameter int DW = 20
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  input  logic [DW-1:0]                 dividend,
  input  logic [pbd_pkg::DIVISOR_W-1:0] divisor,
  output logic [DW-1:0]                 quotient,
  output logic                          done
);

  localparam int CW = $clog2(DW);
  localparam logic [CW-1:0] CNT_LAST = CW'(DW - 1);

  logic [DW-1:0]                   dvd_r, dvd_nxt;
  logic [pbd_pkg::DIVISOR_W-1:0]   dsr_r;
  logic [pbd_pkg::DIVISOR_W-1:0]   rem_r, rem_nxt;
  logic [pbd_pkg::DIVISOR_W:0]     rem_sh, diff;
  logic [CW-1:0]                   cnt_r;
  logic                            busy_r, done_r;
  logic                            ge;

  // One restoring step: bring down the next dividend bit, try the subtract
  always_comb begin
    rem_sh  = {rem_r, dvd_r[DW-1]};
    diff    = rem_sh - {1'b0, dsr_r};
    ge      = ~diff[pbd_pkg::DIVISOR_W];
    rem_nxt = ge ? diff[pbd_pkg::DIVISOR_W-1:0] : rem_sh[pbd_pkg::DIVISOR_W-1:0];
    dvd_nxt = {dvd_r[DW-2:0], ge};
  end

  // Sequence the steps
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + 1'b1;
        if (cnt_r == CNT_LAST) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  // Operand and partial remainder registers
  always_ff @(posedge clk) begin
    if (start) begin
      dvd_r <= dividend;
      dsr_r <= divisor;
      rem_r <= '0;
    end else if (busy_r) begin
      dvd_r <= dvd_nxt;
      rem_r <= rem_nxt;
    end
  end

  assign quotient = dvd_r;
  assign done     = done_r;

endmodule
